### design/stt_pkg.sv
package stt_pkg;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_MINUS  = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_IDENT  = 5'b01000,
    MODE_STRING = 5'b10000
  } scan_mode_e;

  localparam logic [4:0] K_NONE    = 5'd0;
  localparam logic [4:0] K_KEYWORD = 5'd1;
  localparam logic [4:0] K_IDENT   = 5'd2;
  localparam logic [4:0] K_LBRACE  = 5'd3;
  localparam logic [4:0] K_RBRACE  = 5'd4;
  localparam logic [4:0] K_LPAREN  = 5'd5;
  localparam logic [4:0] K_RPAREN  = 5'd6;
  localparam logic [4:0] K_COLON   = 5'd7;
  localparam logic [4:0] K_SEMI    = 5'd8;
  localparam logic [4:0] K_ARROW   = 5'd9;
  localparam logic [4:0] K_STRING  = 5'd10;
  localparam logic [4:0] K_NUMBER  = 5'd11;
  localparam logic [4:0] K_PLUS    = 5'd12;
  localparam logic [4:0] K_MINUS   = 5'd13;
  localparam logic [4:0] K_STAR    = 5'd14;
  localparam logic [4:0] K_SLASH   = 5'd15;
  localparam logic [4:0] K_EQUALS  = 5'd16;

  localparam logic KW_FN     = 1'b0;
  localparam logic KW_RETURN = 1'b1;

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // first characters packed with byte 0 lowest
  localparam logic [47:0] PREFIX_FN     = 48'h0000_0000_6E66;
  localparam logic [47:0] PREFIX_RETURN = 48'h6E72_7574_6572;

  typedef struct packed {
    logic [4:0]  kind;
    logic        kw;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] len;
    logic        unterm;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h3A:   k = K_COLON;
      8'h3B:   k = K_SEMI;
      8'h2B:   k = K_PLUS;
      8'h2A:   k = K_STAR;
      8'h2F:   k = K_SLASH;
      8'h3D:   k = K_EQUALS;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic kw,
                                  input logic [15:0] row, input logic [15:0] col,
                                  input logic [15:0] len, input logic unterm);
    tok_t t;
    t.kind   = kind;
    t.kw     = kw;
    t.row    = row;
    t.col    = col;
    t.len    = len;
    t.unterm = unterm;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

### design/source_text_tokenizer.sv
// Token records are registered into the output queue when their item is accepted, and shown in order.
// Throughput: one item per cycle while in_stall_o is low; the tokenizer state updates in a
// single pass per item. The output queue holds four records and the input stalls once it
// has room for fewer than two, so an item that yields two records always has room for both.
// Reset (rst_ni low, asynchronous): idle mode, row and column zero, output queue empty.
module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        has_character_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic        keyword_id_o,
  output logic [15:0] token_row_o,
  output logic [15:0] token_column_o,
  output logic [15:0] token_length_o,
  output logic        unterminated_o,
  output logic        last_o
);

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  scan_mode_e    mode_q, mode_d;
  logic [PB-1:0] start_q, start_d;
  logic [PB-1:0] run_q, run_d;
  logic [47:0]   prefix_q, prefix_d;
  logic [PB-1:0] col_q, col_d;
  logic [PB-1:0] row_q, row_d;

  tok_t          recs[2];
  logic [1:0]    n_d;
  logic          used;
  logic [4:0]    skind;

  tok_t          fifo_q[4];
  logic [1:0]    rd_q, wr_q;
  logic [2:0]    cnt_q;
  logic          in_acc, out_acc;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == POS_MAX) ? v : v + PB'(1);
  endfunction

  // record for whatever token is pending in the given mode
  function automatic tok_t flush_tok(input scan_mode_e m, input logic [PB-1:0] st,
                                     input logic [PB-1:0] rl, input logic [47:0] pf,
                                     input logic [PB-1:0] rw);
    tok_t t;
    t = mk_tok(K_IDENT, KW_FN, 16'(rw), 16'(st), 16'(rl), 1'b0);
    unique case (m)
      MODE_MINUS: begin
        t.kind = K_MINUS;
        t.len  = 16'd1;
      end
      MODE_NUMBER: t.kind = K_NUMBER;
      MODE_IDENT: begin
        if ((rl == PB'(2)) && (pf == PREFIX_FN)) begin
          t.kind = K_KEYWORD;
        end else if ((rl == PB'(6)) && (pf == PREFIX_RETURN)) begin
          t.kind = K_KEYWORD;
          t.kw   = KW_RETURN;
        end
      end
      MODE_STRING: begin
        t.kind   = K_STRING;
        t.unterm = 1'b1;
      end
      default: t.kind = K_NONE;
    endcase
    return t;
  endfunction

  assign in_stall_o  = (cnt_q > 3'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    run_d    = run_q;
    prefix_d = prefix_q;
    col_d    = col_q;
    row_d    = row_q;
    recs[0]  = '0;
    recs[1]  = '0;
    n_d      = 2'd0;
    used     = 1'b0;
    skind    = single_kind(character_i);

    if (has_character_i) begin
      unique case (mode_q)
        MODE_MINUS: begin
          if (character_i == CH_GT) begin
            recs[n_d[0]] = mk_tok(K_ARROW, KW_FN, 16'(row_q), 16'(start_q), 16'd2, 1'b0);
            used = 1'b1;
          end else begin
            recs[n_d[0]] = flush_tok(mode_q, start_q, run_q, prefix_q, row_q);
          end
          n_d    = n_d + 2'd1;
          mode_d = MODE_IDLE;
        end
        MODE_NUMBER: begin
          if (is_digit(character_i)) begin
            run_d = sat_inc(run_q);
            used  = 1'b1;
          end else begin
            recs[n_d[0]] = flush_tok(mode_q, start_q, run_q, prefix_q, row_q);
            n_d    = n_d + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (is_word(character_i)) begin
            if (run_q < PB'(6)) begin
              prefix_d[{run_q[2:0], 3'b000} +: 8] = character_i;
            end
            run_d = sat_inc(run_q);
            used  = 1'b1;
          end else begin
            recs[n_d[0]] = flush_tok(mode_q, start_q, run_q, prefix_q, row_q);
            n_d    = n_d + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (character_i == CH_QUOTE) begin
            recs[n_d[0]] = mk_tok(K_STRING, KW_FN, 16'(row_q), 16'(start_q),
                                  16'(run_q), 1'b0);
            n_d    = n_d + 2'd1;
            mode_d = MODE_IDLE;
            used   = 1'b1;
          end else if (is_word(character_i)) begin
            run_d = sat_inc(run_q);
            used  = 1'b1;
          end else begin
            recs[n_d[0]] = flush_tok(mode_q, start_q, run_q, prefix_q, row_q);
            n_d    = n_d + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase

      // byte not consumed by a pending token and not white space: emit a one-byte token or start a new one
      if (!used && !is_space(character_i)) begin
        if (skind != K_NONE) begin
          recs[n_d[0]] = mk_tok(skind, KW_FN, 16'(row_q), 16'(col_q), 16'd1, 1'b0);
          n_d = n_d + 2'd1;
        end else begin
          start_d  = col_q;
          run_d    = '0;
          prefix_d = '0;
          if (character_i == CH_DASH) begin
            mode_d = MODE_MINUS;
          end else if (is_digit(character_i)) begin
            mode_d = MODE_NUMBER;
            run_d  = PB'(1);
          end else if (is_alpha(character_i)) begin
            mode_d        = MODE_IDENT;
            prefix_d[7:0] = character_i;
            run_d         = PB'(1);
          end else if (character_i == CH_QUOTE) begin
            mode_d = MODE_STRING;
          end else begin
            recs[n_d[0]] = mk_tok(K_NONE, KW_FN, 16'(row_q), 16'(col_q), 16'd0, 1'b0);
            n_d = n_d + 2'd1;
          end
        end
      end
      col_d = sat_inc(col_q);
    end

    if (end_of_line_i) begin
      if (mode_d != MODE_IDLE) begin
        recs[n_d[0]] = flush_tok(mode_d, start_d, run_d, prefix_d, row_q);
        n_d = n_d + 2'd1;
      end
      mode_d = MODE_IDLE;
      col_d  = '0;
      row_d  = sat_inc(row_q);
    end

    if (n_d == 2'd1) begin
      recs[0].last = 1'b1;
    end else if (n_d == 2'd2) begin
      recs[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      start_q  <= '0;
      run_q    <= '0;
      prefix_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      run_q    <= run_d;
      prefix_q <= prefix_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) begin
        wr_q <= wr_q + n_d;
      end
      if (out_acc) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + (in_acc ? {1'b0, n_d} : 3'd0) - {2'b00, out_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (n_d != 2'd0) begin
        fifo_q[wr_q] <= recs[0];
      end
      if (n_d == 2'd2) begin
        fifo_q[wr_q + 2'd1] <= recs[1];
      end
    end
  end

  assign token_kind_o   = fifo_q[rd_q].kind;
  assign keyword_id_o   = fifo_q[rd_q].kw;
  assign token_row_o    = fifo_q[rd_q].row;
  assign token_column_o = fifo_q[rd_q].col;
  assign token_length_o = fifo_q[rd_q].len;
  assign unterminated_o = fifo_q[rd_q].unterm;
  assign last_o         = fifo_q[rd_q].last;

endmodule

### sim/source_text_tokenizer_tb.sv
module source_text_tokenizer_tb
  import stt_pkg::*;
;

  typedef struct packed {
    logic [7:0] ch;
    logic       hc;
    logic       eol;
  } src_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  character_i = 8'h00;
  logic        has_character_i = 1'b0;
  logic        end_of_line_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  token_kind_o;
  logic        keyword_id_o;
  logic [15:0] token_row_o;
  logic [15:0] token_column_o;
  logic [15:0] token_length_o;
  logic        unterminated_o;
  logic        last_o;

  src_item_t pending[$];
  tok_t      tokens_due[$];
  src_item_t next_item;
  tok_t      want;
  int        items_queued = 0;
  int        token_errors = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  logic      hold_go = 1'b0;
  logic      hold_on = 1'b0;

  // tokenizer state as predicted
  scan_mode_e  lex_mode = MODE_IDLE;
  logic [15:0] tok_start_col = '0;
  logic [15:0] tok_len = '0;
  logic [47:0] tok_prefix = '0;
  logic [15:0] col_pos = '0;
  logic [15:0] row_pos = '0;

  source_text_tokenizer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .has_character_i(has_character_i),
    .end_of_line_i  (end_of_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .keyword_id_o   (keyword_id_o),
    .token_row_o    (token_row_o),
    .token_column_o (token_column_o),
    .token_length_o (token_length_o),
    .unterminated_o (unterminated_o),
    .last_o         (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic bit is_name_char(input logic [7:0] c);
    return is_num(c) || is_letter(c) || (c == CH_UNDER);
  endfunction

  function automatic void push_token(input logic [4:0] kind, input logic kw,
                                     input logic [15:0] col, input logic [15:0] len,
                                     input logic unterm);
    tok_t t;
    t.kind   = kind;
    t.kw     = kw;
    t.row    = row_pos;
    t.col    = col;
    t.len    = len;
    t.unterm = unterm;
    t.last   = 1'b0;
    tokens_due.insert(tokens_due.size(), t);
  endfunction

  function automatic void grow_name(input logic [7:0] c);
    if (tok_len < 16'd6) tok_prefix[tok_len*8 +: 8] = c;
    tok_len = sat16(tok_len);
  endfunction

  // emit whatever token is open and drop back to idle
  function automatic void close_pending();
    case (lex_mode)
      MODE_MINUS:  push_token(K_MINUS, KW_FN, tok_start_col, 16'd1, 1'b0);
      MODE_NUMBER: push_token(K_NUMBER, KW_FN, tok_start_col, tok_len, 1'b0);
      MODE_IDENT: begin
        if (tok_len == 16'd2 && tok_prefix == PREFIX_FN)
          push_token(K_KEYWORD, KW_FN, tok_start_col, tok_len, 1'b0);
        else if (tok_len == 16'd6 && tok_prefix == PREFIX_RETURN)
          push_token(K_KEYWORD, KW_RETURN, tok_start_col, tok_len, 1'b0);
        else
          push_token(K_IDENT, KW_FN, tok_start_col, tok_len, 1'b0);
      end
      MODE_STRING: push_token(K_STRING, KW_FN, tok_start_col, tok_len, 1'b1);
      default: ;
    endcase
    lex_mode = MODE_IDLE;
  endfunction

  function automatic void open_token(input logic [7:0] c, input logic [15:0] col);
    logic [4:0] kind;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    case (c)
      "{":     kind = K_LBRACE;
      "}":     kind = K_RBRACE;
      "(":     kind = K_LPAREN;
      ")":     kind = K_RPAREN;
      ":":     kind = K_COLON;
      ";":     kind = K_SEMI;
      "+":     kind = K_PLUS;
      "*":     kind = K_STAR;
      "/":     kind = K_SLASH;
      "=":     kind = K_EQUALS;
      default: kind = K_NONE;
    endcase
    if (kind != K_NONE) begin
      push_token(kind, KW_FN, col, 16'd1, 1'b0);
      return;
    end
    tok_start_col = col;
    tok_len = '0;
    tok_prefix = '0;
    if (c == CH_DASH) begin
      lex_mode = MODE_MINUS;
    end else if (is_num(c)) begin
      lex_mode = MODE_NUMBER;
      tok_len = 16'd1;
    end else if (is_letter(c)) begin
      lex_mode = MODE_IDENT;
      grow_name(c);
    end else if (c == CH_QUOTE) begin
      lex_mode = MODE_STRING;
    end else begin
      push_token(K_NONE, KW_FN, col, 16'd0, 1'b0);
    end
  endfunction

  function automatic void tokenize_item(input logic [7:0] c, input logic hc,
                                        input logic eol);
    int  first_new;
    bit  taken;
    first_new = tokens_due.size();
    if (hc) begin
      taken = 1'b0;
      case (lex_mode)
        MODE_MINUS: begin
          if (c == CH_GT) begin
            push_token(K_ARROW, KW_FN, tok_start_col, 16'd2, 1'b0);
            lex_mode = MODE_IDLE;
            taken = 1'b1;
          end else close_pending();
        end
        MODE_NUMBER: begin
          if (is_num(c)) begin
            tok_len = sat16(tok_len);
            taken = 1'b1;
          end else close_pending();
        end
        MODE_IDENT: begin
          if (is_name_char(c)) begin
            grow_name(c);
            taken = 1'b1;
          end else close_pending();
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            push_token(K_STRING, KW_FN, tok_start_col, tok_len, 1'b0);
            lex_mode = MODE_IDLE;
            taken = 1'b1;
          end else if (is_name_char(c)) begin
            tok_len = sat16(tok_len);
            taken = 1'b1;
          end else close_pending();
        end
        default: lex_mode = MODE_IDLE;
      endcase
      if (!taken) open_token(c, col_pos);
      col_pos = sat16(col_pos);
    end
    if (eol) begin
      close_pending();
      col_pos = '0;
      row_pos = sat16(row_pos);
    end
    if (tokens_due.size() > first_new) tokens_due[tokens_due.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string what, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      token_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  // sender: hold the payload while stalled, advance once the item is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        tokenize_item(character_i, has_character_i, end_of_line_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_item = pending.pop_front();
          in_valid_i <= 1'b1;
          character_i <= next_item.ch;
          has_character_i <= next_item.hc;
          end_of_line_i <= next_item.eol;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: hold off for a long stretch once asked
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (tokens_due.size() == 0) begin
          token_errors++;
          $display("%0t: unexpected token, expected none, got kind %0d row %0d col %0d",
                   $time, token_kind_o, token_row_o, token_column_o);
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", 32'(want.kind), 32'(token_kind_o));
          check_field("keyword_id", 32'(want.kw), 32'(keyword_id_o));
          check_field("row", 32'(want.row), 32'(token_row_o));
          check_field("column", 32'(want.col), 32'(token_column_o));
          check_field("length", 32'(want.len), 32'(token_length_o));
          check_field("unterminated", 32'(want.unterm), 32'(unterminated_o));
          check_field("last", 32'(want.last), 32'(last_o));
        end
      end
      out_stall_i <= hold_on || ($urandom_range(99) < recv_idle);
    end
  end

  task automatic add_item(input logic [7:0] c, input logic hc, input logic eol);
    src_item_t it;
    it.ch = c;
    it.hc = hc;
    it.eol = eol;
    pending.insert(pending.size(), it);
    if (hc || eol) items_queued++;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_item(s[i], 1'b1, 1'b0);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    pending[pending.size()-1].eol = 1'b1;
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(3))
      0:       return 8'("0" + $urandom_range(9));
      1:       return CH_UNDER;
      default: return rand_letter();
    endcase
  endfunction

  task automatic add_random_line();
    string punct;
    string kw_like[6];
    int    ntok;
    int    i;
    int    j;
    int    len;
    punct = "{}():;+*/=";
    kw_like = '{"fn", "return", "fnx", "retur", "returns", "Fn"};
    ntok = $urandom_range(1, 8);
    for (i = 0; i < ntok; i++) begin
      case ($urandom_range(11))
        0, 1: begin
          len = $urandom_range(0, 8);
          add_item(rand_letter(), 1'b1, 1'b0);
          for (j = 0; j < len; j++) add_item(rand_name_char(), 1'b1, 1'b0);
        end
        2: add_text(kw_like[$urandom_range(5)]);
        3: begin
          len = $urandom_range(1, 5);
          for (j = 0; j < len; j++) add_item(8'("0" + $urandom_range(9)), 1'b1, 1'b0);
        end
        4: begin
          len = $urandom_range(0, 6);
          add_item(CH_QUOTE, 1'b1, 1'b0);
          for (j = 0; j < len; j++) add_item(rand_name_char(), 1'b1, 1'b0);
          if ($urandom_range(4) != 0) add_item(CH_QUOTE, 1'b1, 1'b0);
        end
        5, 6: add_item(punct[$urandom_range(9)], 1'b1, 1'b0);
        7: add_text("->");
        8: add_item(CH_DASH, 1'b1, 1'b0);
        9: add_item(8'($urandom_range(255)), 1'b1, 1'b0);
        10: add_item(8'($urandom_range(255)), 1'b0, 1'b0);
        default: add_item(CH_GT, 1'b1, 1'b0);
      endcase
      if ($urandom_range(2) == 0)
        add_item($urandom_range(1) ? 8'h20 : 8'($urandom_range(9, 13)), 1'b1, 1'b0);
    end
    // close the line on its last byte or with an empty line end
    if ($urandom_range(1)) pending[pending.size()-1].eol = 1'b1;
    else add_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || tokens_due.size() != 0);
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = items_queued + count;
    while (items_queued < goal) add_random_line();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle = 33;
    recv_idle = 79;
    add_line("fn(x:\"s\")->{");
    add_text("return-9z \"a!");
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    add_text("};+*/=_>");
    add_item(8'hFF, 1'b1, 1'b1);
    add_line("\t-");
    add_line("\"q");
    run_random(290);
    wait_drained();

    send_idle = 79;
    recv_idle = 33;
    run_random(290);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    run_random(290);
    @(negedge clk_i);
    hold_go = 1'b1;

    add_line("x=1;\"ab");
    wait_drained();
    repeat (8) @(negedge clk_i);

    if (token_errors == 0) $display("** source_text_tokenizer: PASSED **");
    else $display("** source_text_tokenizer: FAILED **");
    $finish;
  end

  initial begin
    #20000000;
    $display("** source_text_tokenizer: FAILED **");
    $finish;
  end

endmodule
